/* sv/frt_pkg.sv */
// ----------------------------------------------------------------------------
// frt_pkg
// Shared widths, codes and beat types for the flow route table.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HIT_W       = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 3;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] dst;
        logic [31:0] src;
        logic [7:0]  proto;
        logic [15:0] hdr;
    } t_cmd;

    typedef struct packed {
        logic [31:0] dst;
        logic [31:0] src;
        logic [7:0]  proto;
        logic [15:0] hdr;
    } t_entry;

    typedef struct packed {
        t_status          status;
        logic             exact;
        logic [HIT_W-1:0] index;
        logic [7:0]       proto;
        logic [15:0]      hdr;
        logic [31:0]      src;
    } t_result;

endpackage

/* sv/flow_route_table.sv */
// ----------------------------------------------------------------------------
// flow_route_table
// Exact-match route table keyed by destination and source address, with a
// fallback to the last destination-only match.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          contents
//  s         in         i_s_tvalid/o_s_tready/tdata/tuser  command beat
//  m         out        o_m_tvalid/i_m_tready/tdata/tuser  result beat
//
//  lookup and add scan the stored entries through the single read port of
//  the entry memory, one entry per cycle; clear and unknown modes do not
//  scan. reset empties the table at once, no clearing pass.
//  a two-deep command queue and the output register let input and output
//  stall on their own.
// ----------------------------------------------------------------------------
module flow_route_table
    import frt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // dst_addr, src_addr, entry_proto, entry_hdr_size
    input  logic [S_USER_W-1:0] i_s_tuser,  // mode
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // hit_index, hit_proto, hit_hdr_size, hit_src
    output logic [M_USER_W-1:0] o_m_tuser   // status, exact_hit
);

    logic fe_vld;
    logic fe_rdy;
    t_cmd fe_cmd;
    logic q_vld;
    logic q_pop;
    t_cmd q_cmd;

    frt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_cmd_vld  (fe_vld),
        .o_cmd      (fe_cmd),
        .i_cmd_rdy  (fe_rdy)
    );

    frt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (fe_vld),
        .o_push_rdy (fe_rdy),
        .i_push_cmd (fe_cmd),
        .o_pop_vld  (q_vld),
        .i_pop      (q_pop),
        .o_pop_cmd  (q_cmd)
    );

    frt_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (q_vld),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* sv/frt_front.sv */
// ----------------------------------------------------------------------------
// frt_front
// Input stage: takes a beat, decodes the mode into an operation and holds
// the command until the queue takes it.
// ----------------------------------------------------------------------------
module frt_front
    import frt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // dst_addr, src_addr, entry_proto, entry_hdr_size
    input  logic [S_USER_W-1:0] i_s_tuser,  // mode
    output logic                o_cmd_vld,
    output t_cmd                o_cmd,
    input  logic                i_cmd_rdy
);

    logic r_vld;
    logic n_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    t_op  dec_op;
    logic take;

    always_comb begin
        case (i_s_tuser)
            MODE_LOOKUP: dec_op = OP_LOOKUP;
            MODE_ADD:    dec_op = OP_ADD;
            MODE_CLEAR:  dec_op = OP_CLEAR;
            default:     dec_op = OP_NOP;
        endcase
    end

    assign o_s_tready = !r_vld || i_cmd_rdy;
    assign take       = i_s_tvalid && o_s_tready;

    always_comb begin
        n_vld = r_vld && !i_cmd_rdy;
        n_cmd = r_cmd;
        if (take) begin
            n_vld       = 1'b1;
            n_cmd.op    = dec_op;
            n_cmd.dst   = i_s_tdata[31:0];
            n_cmd.src   = i_s_tdata[63:32];
            n_cmd.proto = i_s_tdata[71:64];
            n_cmd.hdr   = i_s_tdata[87:72];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

endmodule

/* sv/frt_queue.sv */
// ----------------------------------------------------------------------------
// frt_queue
// Short command queue between the input stage and the table engine.
// ----------------------------------------------------------------------------
module frt_queue
    import frt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_vld,
    output logic o_push_rdy,
    input  t_cmd i_push_cmd,
    output logic o_pop_vld,
    input  logic i_pop,
    output t_cmd o_pop_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              push;
    logic              pop;

    assign o_push_rdy = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_vld  = r_cnt != '0;
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_pop_vld;
    assign o_pop_cmd  = r_slot[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

/* sv/frt_engine.sv */
// ----------------------------------------------------------------------------
// frt_engine
// Table engine: holds the entry memory, scans it one entry per cycle for
// lookups and adds, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module frt_engine
    import frt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_vld,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // hit_index, hit_proto, hit_hdr_size, hit_src
    output logic [M_USER_W-1:0] o_m_tuser   // status, exact_hit
);

    t_entry            r_mem [TABLE_DEPTH];

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  n_n;
    logic [CNT_W-1:0]  r_addr;
    logic [CNT_W-1:0]  n_addr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_chk_vld;
    logic              n_chk_vld;
    logic [IDX_W-1:0]  r_chk_idx;
    logic [IDX_W-1:0]  n_chk_idx;
    t_entry            r_rd_data;
    logic              r_fb_have;
    logic              n_fb_have;
    logic [IDX_W-1:0]  r_fb_idx;
    logic [IDX_W-1:0]  n_fb_idx;
    t_entry            r_fb_data;
    t_entry            n_fb_data;
    t_result           r_pend;
    t_result           n_pend;
    logic              r_out_vld;
    logic              n_out_vld;
    t_result           r_out;
    t_result           n_out;

    logic              issue;
    logic              exact;
    logic              dst_hit;
    logic              last;
    logic              scan_end;
    logic              out_free;
    logic              table_full;
    logic              cur_fb_have;
    logic [IDX_W-1:0]  cur_fb_idx;
    t_entry            cur_fb_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    t_entry            new_entry;

    function automatic t_result make_entry(logic [IDX_W-1:0] idx, t_entry e,
                                           t_status st, logic ex);
        t_result res;
        res.status = st;
        res.exact  = ex;
        res.index  = HIT_W'(idx);
        res.proto  = e.proto;
        res.hdr    = e.hdr;
        res.src    = e.src;
        return res;
    endfunction

    function automatic t_result make_empty(t_status st);
        t_result res;
        res        = '0;
        res.status = st;
        return res;
    endfunction

    assign issue      = (r_state == S_SCAN) && (r_addr < r_n);
    assign dst_hit    = r_rd_data.dst == r_cmd.dst;
    assign exact      = dst_hit && (r_rd_data.src == r_cmd.src);
    assign last       = (CNT_W'(r_chk_idx) + CNT_W'(1)) == r_n;
    assign scan_end   = r_chk_vld ? (exact || last) : (r_addr == r_n);
    assign out_free   = !r_out_vld || i_m_tready;
    assign table_full = r_count == CNT_W'(TABLE_DEPTH);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_vld;

    assign new_entry.dst   = r_cmd.dst;
    assign new_entry.src   = r_cmd.src;
    assign new_entry.proto = r_cmd.proto;
    assign new_entry.hdr   = r_cmd.hdr;

    always_comb begin
        cur_fb_have = r_fb_have;
        cur_fb_idx  = r_fb_idx;
        cur_fb_data = r_fb_data;
        if (r_chk_vld && dst_hit && (r_cmd.op == OP_LOOKUP)) begin
            cur_fb_have = 1'b1;
            cur_fb_idx  = r_chk_idx;
            cur_fb_data = r_rd_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    if ((i_cmd.op == OP_LOOKUP) || (i_cmd.op == OP_ADD)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd     = r_cmd;
        n_n       = r_n;
        n_addr    = r_addr;
        n_count   = r_count;
        n_chk_vld = 1'b0;
        n_chk_idx = r_addr[IDX_W-1:0];
        n_fb_have = r_fb_have;
        n_fb_idx  = r_fb_idx;
        n_fb_data = r_fb_data;
        n_pend    = r_pend;
        n_out_vld = r_out_vld && !i_m_tready;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_addr   = r_count[IDX_W-1:0];
        wr_data   = new_entry;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    n_cmd     = i_cmd;
                    n_n       = r_count;
                    n_addr    = '0;
                    n_fb_have = 1'b0;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_pend  = make_empty(ST_OK);
                        end
                        default: n_pend = make_empty(ST_MISS);
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                n_chk_vld = issue && !scan_end;
                n_fb_have = cur_fb_have;
                n_fb_idx  = cur_fb_idx;
                n_fb_data = cur_fb_data;
                if (scan_end) begin
                    if (r_chk_vld && exact) begin
                        if (r_cmd.op == OP_LOOKUP) begin
                            n_pend = make_entry(r_chk_idx, r_rd_data, ST_OK, 1'b1);
                        end else begin
                            n_pend = make_entry(r_chk_idx, r_rd_data, ST_DUP, 1'b0);
                        end
                    end else if (r_cmd.op == OP_LOOKUP) begin
                        if (cur_fb_have) begin
                            n_pend = make_entry(cur_fb_idx, cur_fb_data, ST_OK, 1'b0);
                        end else begin
                            n_pend = make_empty(ST_MISS);
                        end
                    end else if (table_full) begin
                        n_pend = make_empty(ST_FULL);
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_pend  = make_entry(r_count[IDX_W-1:0], new_entry, ST_OK, 1'b0);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_pend;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_n       <= n_n;
        r_addr    <= n_addr;
        r_chk_idx <= n_chk_idx;
        r_fb_have <= n_fb_have;
        r_fb_idx  <= n_fb_idx;
        r_fb_data <= n_fb_data;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out.src, r_out.hdr, r_out.proto, r_out.index};
    assign o_m_tuser  = {r_out.exact, r_out.status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count < CNT_W'(TABLE_DEPTH)) && (r_state == S_SCAN))
        else $error("table write while full or outside scan");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_state == S_SCAN) && (CNT_W'(r_chk_idx) < r_n))
        else $error("compare beat outside scan range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1)) || (r_count == '0))
        else $error("entry count moved by more than one");

endmodule

/* test/flow_route_checker.sv */
// ----------------------------------------------------------------------------
// flow_route_checker
// Watches the command and result channels of the flow route table, keeps a
// shadow copy of the table, works out the result of every accepted command
// beat and compares each result beat, field by field, with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module flow_route_checker
    import frt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // dst_addr, src_addr, entry_proto, entry_hdr_size
    input  logic [S_USER_W-1:0] i_s_tuser,  // mode
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,  // hit_index, hit_proto, hit_hdr_size, hit_src
    input  logic [M_USER_W-1:0] i_m_tuser,  // status, exact_hit
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [31:0] shadow_dst   [TABLE_DEPTH];
    logic [31:0] shadow_src   [TABLE_DEPTH];
    logic [7:0]  shadow_proto [TABLE_DEPTH];
    logic [15:0] shadow_hdr   [TABLE_DEPTH];
    int          shadow_count = 0;

    t_result     route_expect_q[$];
    int          fail_count   = 0;
    int          pending      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic t_result entry_result(input int idx, input t_status status,
                                             input logic exact);
        t_result r;
        r.status = status;
        r.exact  = exact;
        r.index  = idx[HIT_W-1:0];
        r.proto  = shadow_proto[idx];
        r.hdr    = shadow_hdr[idx];
        r.src    = shadow_src[idx];
        return r;
    endfunction

    function automatic t_result predict_route(input t_op op, input logic [31:0] dst,
                                              input logic [31:0] src,
                                              input logic [7:0] proto,
                                              input logic [15:0] hdr);
        t_result r;
        bit      have_dst;
        int      last_dst;
        r        = '0;
        have_dst = 0;
        last_dst = 0;
        case (op)
            OP_LOOKUP: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_dst[i] == dst) begin
                        if (shadow_src[i] == src)
                            return entry_result(i, ST_OK, 1'b1);
                        have_dst = 1;
                        last_dst = i;
                    end
                end
                if (have_dst)
                    r = entry_result(last_dst, ST_OK, 1'b0);
                else
                    r.status = ST_MISS;
            end
            OP_ADD: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_dst[i] == dst && shadow_src[i] == src)
                        return entry_result(i, ST_DUP, 1'b0);
                end
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_dst[shadow_count]   = dst;
                    shadow_src[shadow_count]   = src;
                    shadow_proto[shadow_count] = proto;
                    shadow_hdr[shadow_count]   = hdr;
                    shadow_count++;
                    r = entry_result(shadow_count - 1, ST_OK, 1'b0);
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
                r.status     = ST_OK;
            end
            default: begin
                r.status = ST_MISS;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                route_expect_q.push_back(predict_route(t_op'(i_s_tuser), i_s_tdata[31:0],
                                                       i_s_tdata[63:32], i_s_tdata[71:64],
                                                       i_s_tdata[87:72]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (route_expect_q.size() == 0) begin
                    report_mismatch("unexpected result beat", i_m_tdata[31:0], '0);
                end else begin
                    want = route_expect_q.pop_front();
                    if (i_m_tuser[1:0] !== want.status)
                        report_mismatch("status", i_m_tuser[1:0], want.status);
                    if (i_m_tuser[2] !== want.exact)
                        report_mismatch("exact_hit", i_m_tuser[2], want.exact);
                    if (i_m_tdata[5:0] !== want.index)
                        report_mismatch("hit_index", i_m_tdata[5:0], want.index);
                    if (i_m_tdata[13:6] !== want.proto)
                        report_mismatch("hit_proto", i_m_tdata[13:6], want.proto);
                    if (i_m_tdata[29:14] !== want.hdr)
                        report_mismatch("hit_hdr_size", i_m_tdata[29:14], want.hdr);
                    if (i_m_tdata[61:30] !== want.src)
                        report_mismatch("hit_src", i_m_tdata[61:30], want.src);
                end
            end
            pending = route_expect_q.size();
        end
    end

endmodule

/* test/tb_flow_route_table.sv */
// ----------------------------------------------------------------------------
// tb_flow_route_table
// Drives command beats into the flow route table: a directed opening on
// field extremes, duplicates, fallback and clear, then random blocks that
// fill the table to capacity or mix adds and lookups over small key pools.
// Sender gaps and receiver stalls vary by phase, with one long output
// hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_flow_route_table;
    import frt_pkg::*;

    localparam int N_RANDOM   = 880;
    localparam int POOL_N     = 8;
    localparam int HOLD_LEN   = 500;

    typedef enum int {
        PH_FREE,
        PH_SND_IDLE,
        PH_RCV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    int          fail_count;
    int          pending;
    t_phase      phase         = PH_FREE;
    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int          beats_sent    = 0;
    int          hold_left     = 0;
    bit          hold_done     = 0;
    logic [31:0] pool_dst [POOL_N];
    logic [31:0] pool_src [POOL_N];

    flow_route_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    flow_route_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver side, owns the long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (phase == PH_PRESSURE && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input t_op op, input logic [31:0] dst, input logic [31:0] src,
                             input logic [7:0] proto, input logic [15:0] hdr);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {hdr, proto, src, dst};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic pick_phase();
        phase = t_phase'((beats_sent / (N_RANDOM / 10)) % 5);
        case (phase)
            PH_FREE:      begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            PH_SND_IDLE:  begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
            PH_RCV_STALL: begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
            PH_BOTH:      begin snd_idle_pct = 11; rcv_stall_pct = 11; end
            default:      begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        endcase
    endtask

    initial begin
        int        len;
        int        r;
        logic [31:0] dst;
        logic [31:0] src;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed opening
        send_beat(OP_LOOKUP, 32'h0, 32'h0, 8'h00, 16'h0000);
        send_beat(OP_ADD,    32'h0, 32'h0, 8'h00, 16'h0000);
        send_beat(OP_ADD,    32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
        send_beat(OP_ADD,    32'h0, 32'h0, 8'h12, 16'h3456);
        send_beat(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 8'h00, 16'h0000);
        send_beat(OP_ADD,    32'h0, 32'h5555_5555, 8'ha5, 16'h5a5a);
        send_beat(OP_LOOKUP, 32'h0, 32'haaaa_aaaa, 8'hff, 16'hffff);
        send_beat(OP_ADD,    32'haaaa_aaaa, 32'h0, 8'h5a, 16'ha5a5);
        send_beat(OP_ADD,    32'haaaa_aaaa, 32'h1234_5678, 8'h01, 16'h0001);
        send_beat(OP_LOOKUP, 32'haaaa_aaaa, 32'h1234_5678, 8'h00, 16'h0000);
        send_beat(OP_LOOKUP, 32'h0, 32'h5555_5555, 8'h00, 16'h0000);
        send_beat(OP_LOOKUP, 32'h1, 32'h0, 8'h00, 16'h0000);
        send_beat(OP_NOP,    32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
        send_beat(OP_CLEAR,  32'hffff_ffff, 32'hffff_ffff, 8'hff, 16'hffff);
        send_beat(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 8'h00, 16'h0000);
        send_beat(OP_ADD,    32'h8000_0000, 32'h0000_0001, 8'h80, 16'h8000);
        send_beat(OP_LOOKUP, 32'h8000_0000, 32'h0000_0001, 8'h00, 16'h0000);
        send_beat(OP_CLEAR,  32'h0, 32'h0, 8'h00, 16'h0000);

        beats_sent = 0;
        while (beats_sent < N_RANDOM) begin
            pick_phase();
            for (int i = 0; i < POOL_N; i++) begin
                pool_dst[i] = $urandom();
                pool_src[i] = $urandom();
            end
            if ($urandom_range(3) == 0) begin
                // fill to capacity, then duplicates, lookups and overflow
                send_beat(OP_CLEAR, $urandom(), $urandom(), 8'($urandom()), 16'($urandom()));
                for (int i = 0; i < TABLE_DEPTH; i++)
                    send_beat(OP_ADD, pool_dst[i / POOL_N], pool_src[i % POOL_N],
                              8'($urandom()), 16'($urandom()));
                for (int i = 0; i < 12; i++) begin
                    r = $urandom_range(2);
                    if (r == 0)
                        send_beat(OP_ADD, $urandom(), $urandom(), 8'($urandom()),
                                  16'($urandom()));
                    else
                        send_beat(r == 1 ? OP_ADD : OP_LOOKUP,
                                  pool_dst[$urandom_range(POOL_N - 1)],
                                  pool_src[$urandom_range(POOL_N - 1)],
                                  8'($urandom()), 16'($urandom()));
                end
            end else begin
                if ($urandom_range(1))
                    send_beat(OP_CLEAR, $urandom(), $urandom(), 8'($urandom()),
                              16'($urandom()));
                len = $urandom_range(10, 60);
                for (int i = 0; i < len; i++) begin
                    r   = $urandom_range(99);
                    dst = pool_dst[$urandom_range(POOL_N - 1)];
                    src = ($urandom_range(3) == 0) ? $urandom()
                                                   : pool_src[$urandom_range(POOL_N - 1)];
                    if (r < 45)
                        send_beat(OP_ADD, dst, src, 8'($urandom()), 16'($urandom()));
                    else if (r < 85)
                        send_beat(OP_LOOKUP, dst, src, 8'($urandom()), 16'($urandom()));
                    else if (r < 92)
                        send_beat(r[0] ? OP_ADD : OP_LOOKUP, $urandom(), $urandom(),
                                  8'($urandom()), 16'($urandom()));
                    else if (r < 96)
                        send_beat(OP_CLEAR, $urandom(), $urandom(), 8'($urandom()),
                                  16'($urandom()));
                    else
                        send_beat(OP_NOP, $urandom(), $urandom(), 8'($urandom()),
                                  16'($urandom()));
                end
            end
        end
        s_tvalid = 1'b0;

        wait (pending == 0);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
